// ===== sv/itoa_pkg.sv =====
// itoa_pkg: shared constants, state and command/status types for the
// signed integer to decimal ascii block; no dependencies
package itoa_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned MaxDigits  = 10;
    localparam int unsigned IdxWidth   = $clog2(MaxDigits + 1);

    // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
    localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
    localparam int unsigned RecipShift = 35;

    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiMinus = 8'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic pop;
        logic show_sign;
    } t_dp_cmd;

    typedef struct packed {
        logic negative;
        logic quot_zero;
        logic digits_full;
        logic last_digit;
    } t_dp_status;

endpackage

// ===== sv/itoa_dp.sv =====
// itoa_dp: datapath, magnitude register, reciprocal divide by ten and
// digit store; depends on itoa_pkg
module itoa_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itoa_pkg::t_dp_cmd    i_cmd,
    input  logic [31:0]          i_value,
    output itoa_pkg::t_dp_status o_status,
    output logic [7:0]           o_text_char,
    output logic                 o_last_char
);
    import itoa_pkg::*;

    logic [ValueWidth-1:0]   r_mag;
    logic [2*ValueWidth-1:0] r_prod;
    logic                    r_neg;
    logic [3:0]              r_digits [MaxDigits];
    logic [IdxWidth-1:0]     r_ndig;

    logic [ValueWidth-1:0]            w_load_mag;
    logic [ValueWidth-RecipShift+31:0] w_quot;
    logic [ValueWidth-1:0]            w_quot_x10;
    logic [ValueWidth-1:0]            w_rem;
    logic [IdxWidth-1:0]              w_rd_idx;

    assign w_load_mag = i_value[31] ? (32'd0 - i_value) : i_value;
    assign w_quot     = r_prod[2*ValueWidth-1:RecipShift];
    assign w_quot_x10 = ValueWidth'({w_quot, 3'b000}) + ValueWidth'({w_quot, 1'b0});
    assign w_rem      = r_mag - w_quot_x10;
    assign w_rd_idx   = r_ndig - IdxWidth'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= w_load_mag;
            r_neg <= i_value[31];
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_mag) * 64'(RecipTen);
        end
        if (i_cmd.div) begin
            r_mag <= ValueWidth'(w_quot);
            r_digits[r_ndig[3:0]] <= w_rem[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= '0;
        end else if (i_cmd.load) begin
            r_ndig <= '0;
        end else if (i_cmd.div) begin
            r_ndig <= r_ndig + IdxWidth'(1);
        end else if (i_cmd.pop) begin
            r_ndig <= w_rd_idx;
        end
    end

    always_comb begin
        o_status.negative    = r_neg;
        o_status.quot_zero   = (w_quot == '0);
        o_status.digits_full = (r_ndig == IdxWidth'(MaxDigits - 1));
        o_status.last_digit  = (r_ndig == IdxWidth'(1));
        if (i_cmd.show_sign) begin
            o_text_char = AsciiMinus;
            o_last_char = 1'b0;
        end else begin
            o_text_char = AsciiZero + {4'b0000, r_digits[w_rd_idx[3:0]]};
            o_last_char = (r_ndig == IdxWidth'(1));
        end
    end

    a_rem_below_ten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> (w_rem < 32'd10))
        else $error("remainder of divide by ten out of range");

    a_pop_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_ndig != '0) && (r_ndig <= IdxWidth'(MaxDigits)))
        else $error("digit popped from empty store");

endmodule

// ===== sv/itoa_ctrl.sv =====
// itoa_ctrl: controller state machine sequencing load, divide and emit;
// depends on itoa_pkg
module itoa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  itoa_pkg::t_dp_status i_status,
    output itoa_pkg::t_dp_cmd    o_cmd
);
    import itoa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.quot_zero || i_status.digits_full) begin
                    n_state = i_status.negative ? S_SIGN : S_DIGIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                if (i_ready) n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_ready && i_status.last_digit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_SIGN: begin
                o_valid         = 1'b1;
                o_cmd.show_sign = 1'b1;
            end
            S_DIGIT: begin
                o_valid   = 1'b1;
                o_cmd.pop = i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    a_one_side_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while characters pending");

    a_load_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MUL))
        else $error("accepted request did not start conversion");

endmodule

// ===== sv/signed_integer_to_decimal_ascii_top.sv =====
// signed_integer_to_decimal_ascii_top: signed 32-bit integer to decimal
// ascii text; depends on itoa_pkg, itoa_ctrl and itoa_dp
//
// input channel: i_valid / o_ready with i_value (two's complement)
// output channel: o_valid / i_ready with o_text_char and o_last_char
// each request produces 1 to 11 characters, most significant first: '-' for
// a negative value, then the digits with no leading zeros; o_last_char marks
// the final character of the run
// the magnitude is divided by ten with a 32x32 reciprocal multiply, each
// digit taking a multiply step and then a quotient and remainder step;
// digits are stored and then emitted one per cycle while i_ready is high
// the first character is offered only once all of the digits (1 to 10)
// have been produced
// one request is in flight at a time; o_ready is high only while idle
// a stall on i_ready holds the current character and mark unchanged
// reset returns the block to idle and drops any run in progress
module signed_integer_to_decimal_ascii_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last_char
);
    import itoa_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    itoa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_status    (w_status),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for signed_integer_to_decimal_ascii_top
// a directed table, then bursts of random values under random back-pressure
// depends on itoa_pkg and signed_integer_to_decimal_ascii_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] char_q_t [$];

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    localparam int NumDirected = 22;
    localparam int NumRandom   = 240;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_text_char;
    logic        o_last_char;

    text_char_t chars_due [$];
    string      typed_texts [$];
    int         mismatch_count = 0;
    bit         hold_off_req = 1'b0;

    logic [31:0] directed_value [NumDirected] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd42, -32'sd7,
        32'd99, 32'd100, -32'sd100000, 32'd9999, 32'd999999999, 32'd1000000000,
        -32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA
    };

    // empty text means the value is checked against the formatter below
    string directed_text [NumDirected] = '{
        "0", "1", "-1", "9", "10", "-10", "", "",
        "", "", "", "", "999999999", "1000000000",
        "", "1234567890", "", "2147483647",
        "-2147483648", "-2147483647", "", ""
    };

    signed_integer_to_decimal_ascii_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic char_q_t decimal_text(logic [31:0] bits);
        char_q_t     text;
        logic [31:0] mag;
        mag = bits[31] ? (32'd0 - bits) : bits;
        do begin
            text.push_front(itoa_pkg::AsciiZero + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 0);
        if (bits[31]) begin
            text.push_front(itoa_pkg::AsciiMinus);
        end
        return text;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned tens [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                   10000000, 100000000, 1000000000};
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 99);
            3: v = tens[$urandom_range(0, 9)] - $urandom_range(0, 1);
            4: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                        : 32'h8000_0000 + $urandom_range(0, 15);
            default: v = $urandom_range(0, 99999);
        endcase
        if ($urandom_range(0, 1) && !v[31]) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // request and character checking
    always @(posedge i_clk) begin : watch
        char_q_t    text;
        string      typed;
        text_char_t due;
        if (i_rst_n && i_valid && o_ready) begin
            typed = typed_texts.pop_front();
            if (typed.len() == 0) begin
                text = decimal_text(i_value);
            end else begin
                text = {};
                for (int k = 0; k < typed.len(); k++) text.push_back(typed[k]);
            end
            foreach (text[k]) begin
                chars_due.push_back('{ch: text[k], last: (k == text.size() - 1)});
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (chars_due.size() == 0) begin
                $error("character %h with no request outstanding", o_text_char);
                mismatch_count++;
            end else begin
                due = chars_due.pop_front();
                if (o_text_char !== due.ch) begin
                    $error("text_char expected %h actual %h", due.ch, o_text_char);
                    mismatch_count++;
                end
                if (o_last_char !== due.last) begin
                    $error("last_char expected %b actual %b", due.last, o_last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: stall pattern chosen from the cycle counter, plus long hold-offs
    initial begin : receiver
        int unsigned cycle;
        int unsigned hold_left;
        cycle = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 150;
                i_ready <= 1'b0;
            end else begin
                case (cycle[8:6])
                    0, 1: i_ready <= 1'b1;
                    2: i_ready <= 1'($urandom_range(0, 1));
                    3: i_ready <= (cycle % 7) != 3;
                    4: i_ready <= cycle[2];
                    5: i_ready <= $urandom_range(0, 9) != 0;
                    6: i_ready <= $urandom_range(0, 3) == 0;
                    default: i_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic offer(logic [31:0] v, string typed);
        typed_texts.push_back(typed);
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic pause(int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic await_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NumDirected; n++) begin
            offer(directed_value[n], directed_text[n]);
            pause($urandom_range(0, 2));
        end
        await_drain();

        sent = 0;
        while (sent < NumRandom) begin
            if (sent >= 60 && sent < 70) begin
                // receiver holds off while requests keep coming
                hold_off_req = 1'b1;
                repeat (8) begin
                    offer(pick_value(), "");
                    sent++;
                end
            end else if (sent >= 150 && sent < 160) begin
                await_drain();
                sent = 160 + sent % 10;
            end
            burst = $urandom_range(1, 10);
            for (int j = 0; j < burst && sent < NumRandom; j++) begin
                offer(pick_value(), "");
                sent++;
            end
            case ($urandom_range(0, 7))
                0, 1, 2: pause(0);
                3: pause(40);
                default: pause($urandom_range(1, 12));
            endcase
        end
        await_drain();
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
